[hdl/cpik_pkg.sv]
// ----------------------------------------------------------------------------
// cpik_pkg
// Shared types, status codes and constants for the planar chain IK solver.
// ----------------------------------------------------------------------------
package cpik_pkg;

   localparam int CW_W = 44;
   localparam int CZ_W = 34;
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;
   localparam logic [15:0] HALF_TURN = 16'h8000;

   localparam logic [2:0] ST_ROOT_SET = 3'd0;
   localparam logic [2:0] ST_ADDED    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_SOLVED   = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef struct packed {
      logic               action;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         bone_index;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [15:0]        out_angle;
      logic [16:0]        out_length;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic               rotate;
      logic signed [21:0] dx;
      logic signed [21:0] dy;
      logic [16:0]        len;
      logic [15:0]        ang;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic [15:0]        angle;
      logic signed [19:0] ox;
      logic signed [19:0] oy;
   } cordic_rsp_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
                                                 input logic signed [19:0] b);
      logic signed [20:0] s;
      logic signed [15:0] r;
      s = 21'(a) + 21'(b);
      if (s > 21'sd32767) r = 16'sh7fff;
      else if (s < -21'sd32768) r = 16'sh8000;
      else r = s[15:0];
      return r;
   endfunction

endpackage

[hdl/cpik_cordic.sv]
// ----------------------------------------------------------------------------
// cpik_cordic
// Iterative CORDIC, one micro-rotation per cycle: vectoring (atan2) or
// rotation (polar to cartesian with gain precompensation).
// ----------------------------------------------------------------------------
module cpik_cordic #(
   parameter int ITERS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cpik_pkg::cordic_req_type creq,
   output cpik_pkg::cordic_rsp_type crsp
);
   import cpik_pkg::*;

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_RUN  = 3'b010,
      C_FIN  = 3'b100
   } cstate_type;

   cstate_type            state_ff, state_in;
   logic signed [CW_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CZ_W-1:0] z_ff, z_in;
   logic [4:0]            i_ff, i_in;
   logic                  rot_ff, rot_in, flip_ff, flip_in, zero_ff, zero_in;
   cordic_rsp_type        rsp_ff, rsp_in;

   logic signed [CW_W-1:0] xs, ys, vx, vy, rx, ry;
   logic signed [CZ_W-1:0] at;
   logic [31:0]           z32, zt, zr;
   logic [46:0]           prod;
   logic                  dir;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      rot_in   = rot_ff;
      flip_in  = flip_ff;
      zero_in  = zero_ff;
      rsp_in   = rsp_ff;
      rsp_in.done = 1'b0;
      xs   = x_ff >>> i_ff;
      ys   = y_ff >>> i_ff;
      at   = CZ_W'(atan_lut(i_ff));
      dir  = rot_ff ? (z_ff >= 0) : !(y_ff > 0);
      z32  = {creq.ang, 16'h0000};
      zt   = z32 + 32'h4000_0000;
      prod = 47'(creq.len) * 47'(GAIN_Q30);
      vx   = CW_W'(creq.dx) <<< 14;
      vy   = CW_W'(creq.dy) <<< 14;
      rx   = (x_ff + CW_W'(32768)) >>> 16;
      ry   = (y_ff + CW_W'(32768)) >>> 16;
      zr   = z_ff[31:0] + 32'h0000_8000;
      case (state_ff)
         C_IDLE: begin
            if (creq.start) begin
               rot_in   = creq.rotate;
               i_in     = 5'd0;
               state_in = C_RUN;
               if (creq.rotate) begin
                  flip_in = zt[31];
                  z_in    = CZ_W'($signed(zt[31] ? z32 + 32'h8000_0000 : z32));
                  x_in    = CW_W'(prod >> 14);
                  y_in    = '0;
                  zero_in = 1'b0;
               end else begin
                  flip_in = 1'b0;
                  zero_in = (creq.dx == 0) && (creq.dy == 0);
                  if (creq.dx < 0) begin
                     x_in = -vx;
                     y_in = -vy;
                     z_in = CZ_W'(33'h0_8000_0000);
                  end else begin
                     x_in = vx;
                     y_in = vy;
                     z_in = '0;
                  end
               end
            end
         end
         C_RUN: begin
            if (dir) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(ITERS - 1)) state_in = C_FIN;
         end
         C_FIN: begin
            rsp_in.done  = 1'b1;
            rsp_in.angle = zero_ff ? 16'h0000 : zr[31:16];
            rsp_in.ox    = flip_ff ? -rx[19:0] : rx[19:0];
            rsp_in.oy    = flip_ff ? -ry[19:0] : ry[19:0];
            state_in     = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= C_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rsp_ff.done <= rsp_in.done;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      i_ff         <= i_in;
      rot_ff       <= rot_in;
      flip_ff      <= flip_in;
      zero_ff      <= zero_in;
      rsp_ff.angle <= rsp_in.angle;
      rsp_ff.ox    <= rsp_in.ox;
      rsp_ff.oy    <= rsp_in.oy;
   end

   assign crsp = rsp_ff;

endmodule

[hdl/cpik_isqrt.sv]
// ----------------------------------------------------------------------------
// cpik_isqrt
// Bone length: squares dx and dy on one multiplier, then a digit-by-digit
// integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cpik_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [16:0] dx,
   input  logic signed [16:0] dy,
   output logic               done,
   output logic [16:0]        root
);
   import cpik_pkg::*;

   typedef enum logic [3:0] {
      Q_IDLE = 4'b0001,
      Q_SQY  = 4'b0010,
      Q_RUN  = 4'b0100,
      Q_FIN  = 4'b1000
   } qstate_type;

   qstate_type  state_ff, state_in;
   logic [33:0] val_ff, val_in;
   logic [19:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [4:0]  i_ff, i_in;
   logic        done_ff, done_in;
   logic signed [16:0] dy_ff, dy_in;

   logic signed [16:0] mop;
   logic signed [33:0] sq;
   logic [19:0] rem_sh, trial;

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      i_in     = i_ff;
      dy_in    = dy_ff;
      done_in  = 1'b0;
      mop      = (state_ff == Q_SQY) ? dy_ff : dx;
      sq       = mop * mop;
      rem_sh   = {rem_ff[17:0], val_ff[33:32]};
      trial    = {1'b0, root_ff, 2'b01};
      case (state_ff)
         Q_IDLE: begin
            if (start) begin
               val_in   = $unsigned(sq);
               dy_in    = dy;
               state_in = Q_SQY;
            end
         end
         Q_SQY: begin
            val_in   = val_ff + $unsigned(sq);
            rem_in   = '0;
            root_in  = '0;
            i_in     = 5'd0;
            state_in = Q_RUN;
         end
         Q_RUN: begin
            val_in = {val_ff[31:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[15:0], 1'b0};
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'd16) state_in = Q_FIN;
         end
         Q_FIN: begin
            done_in  = 1'b1;
            state_in = Q_IDLE;
         end
         default: state_in = Q_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      i_ff    <= i_in;
      dy_ff   <= dy_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hdl/planar_chain_ik_solver.sv]
// Root set, full and empty answer straight from idle. Add rotates out the last tip,
//   squares and vectors, skipping the rotation on the first bone. Step on n bones
//   gives one result per bone; both are paced by the shared CORDIC unit.
// Throughput: one transaction at a time; req_ready only while idle.
// Reset (synchronous, active high) clears root and bone count; joint storage
//   is not cleared and is read only below the bone count.
// ----------------------------------------------------------------------------
// planar_chain_ik_solver
// FABRIK-style 2D chain solver: sequencer around a shared CORDIC and isqrt.
// ----------------------------------------------------------------------------
module planar_chain_ik_solver #(
   parameter int MAX_BONES    = 16,
   parameter int CORDIC_ITERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cpik_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpik_pkg::rsp_type rsp_data
);
   import cpik_pkg::*;

   localparam int IW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int CW = $clog2(MAX_BONES + 1);

   typedef enum logic [17:0] {
      S_IDLE   = 18'h00001,
      S_A_ROT  = 18'h00002,
      S_A_ROTW = 18'h00004,
      S_A_SQ   = 18'h00008,
      S_A_SQW  = 18'h00010,
      S_A_VEC  = 18'h00020,
      S_A_VECW = 18'h00040,
      S_B_VEC  = 18'h00080,
      S_B_VECW = 18'h00100,
      S_B_ROT  = 18'h00200,
      S_B_ROTW = 18'h00400,
      S_F_ROT1 = 18'h00800,
      S_F_RT1W = 18'h01000,
      S_F_VEC  = 18'h02000,
      S_F_VECW = 18'h04000,
      S_F_ROT2 = 18'h08000,
      S_F_RT2W = 18'h10000,
      S_OUT    = 18'h20000
   } state_type;

   state_type          state_ff, state_in;
   logic               has_root_ff, has_root_in;
   logic signed [15:0] root_x_ff, root_x_in, root_y_ff, root_y_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in, tx_ff, tx_in, ty_ff, ty_in;
   logic signed [20:0] tipx_ff, tipx_in, tipy_ff, tipy_in;
   logic [16:0]        slen_ff, slen_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [15:0] jx_ff [MAX_BONES];
   logic signed [15:0] jy_ff [MAX_BONES];
   logic [15:0]        hd_ff [MAX_BONES];
   logic [16:0]        len_ff [MAX_BONES];

   logic               j_we, hd_we, len_we;
   logic [IW-1:0]      wr_idx;
   logic signed [15:0] wjx, wjy;
   logic [15:0]        whd;

   logic signed [15:0] rjx, rjy;
   logic [15:0]        rhd;
   logic [16:0]        rlen;
   logic signed [15:0] nx, ny;

   cordic_req_type     creq;
   cordic_rsp_type     crsp;
   logic               sq_start, sq_done;
   logic [16:0]        sq_root;
   logic signed [16:0] sdx, sdy;

   cpik_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
      .clock(clock), .reset(reset), .creq(creq), .crsp(crsp)
   );

   cpik_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .dx(sdx), .dy(sdy),
      .done(sq_done), .root(sq_root)
   );

   assign rjx  = jx_ff[idx_ff];
   assign rjy  = jy_ff[idx_ff];
   assign rhd  = hd_ff[idx_ff];
   assign rlen = len_ff[idx_ff];
   assign sdx  = 17'(px_ff) - 17'(tx_ff);
   assign sdy  = 17'(py_ff) - 17'(ty_ff);
   assign nx   = add_sat(tx_ff, crsp.ox);
   assign ny   = add_sat(ty_ff, crsp.oy);

   always_comb begin
      creq        = '0;
      creq.len    = rlen;
      creq.ang    = rhd;
      creq.rotate = 1'b1;
      sq_start    = 1'b0;
      case (state_ff)
         S_A_ROT, S_F_ROT1, S_F_ROT2: creq.start = 1'b1;
         S_B_ROT: begin
            creq.start = 1'b1;
            creq.ang   = rhd + HALF_TURN;
         end
         S_A_VEC: begin
            creq.start  = 1'b1;
            creq.rotate = 1'b0;
            creq.dx     = 22'(px_ff) - 22'(tx_ff);
            creq.dy     = 22'(py_ff) - 22'(ty_ff);
         end
         S_B_VEC: begin
            creq.start  = 1'b1;
            creq.rotate = 1'b0;
            creq.dx     = 22'(tx_ff) - 22'(rjx);
            creq.dy     = 22'(ty_ff) - 22'(rjy);
         end
         S_F_VEC: begin
            creq.start  = 1'b1;
            creq.rotate = 1'b0;
            creq.dx     = 22'(tipx_ff) - 22'(tx_ff);
            creq.dy     = 22'(tipy_ff) - 22'(ty_ff);
         end
         S_A_SQ: sq_start = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      has_root_in = has_root_ff;
      root_x_in   = root_x_ff;
      root_y_in   = root_y_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      tipx_in     = tipx_ff;
      tipy_in     = tipy_ff;
      slen_in     = slen_ff;
      rsp_in      = rsp_ff;
      j_we        = 1'b0;
      hd_we       = 1'b0;
      len_we      = 1'b0;
      wr_idx      = idx_ff;
      wjx         = tx_ff;
      wjy         = ty_ff;
      whd         = crsp.angle;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               px_in  = req_data.point_x;
               py_in  = req_data.point_y;
               rsp_in = '0;
               rsp_in.last = 1'b1;
               state_in = S_OUT;
               if (req_data.action == ACT_ADD) begin
                  if (!has_root_ff) begin
                     has_root_in   = 1'b1;
                     root_x_in     = req_data.point_x;
                     root_y_in     = req_data.point_y;
                     rsp_in.status = ST_ROOT_SET;
                     rsp_in.out_x  = req_data.point_x;
                     rsp_in.out_y  = req_data.point_y;
                  end else if (count_ff == CW'(MAX_BONES)) begin
                     rsp_in.status = ST_FULL;
                  end else if (count_ff == '0) begin
                     tx_in    = root_x_ff;
                     ty_in    = root_y_ff;
                     state_in = S_A_SQ;
                  end else begin
                     idx_in   = IW'(count_ff - 1'b1);
                     state_in = S_A_ROT;
                  end
               end else if (count_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  idx_in   = IW'(count_ff - 1'b1);
                  tx_in    = req_data.point_x;
                  ty_in    = req_data.point_y;
                  state_in = S_B_VEC;
               end
            end
         end
         S_A_ROT:  state_in = S_A_ROTW;
         S_A_ROTW: begin
            if (crsp.done) begin
               tx_in    = add_sat(rjx, crsp.ox);
               ty_in    = add_sat(rjy, crsp.oy);
               state_in = S_A_SQ;
            end
         end
         S_A_SQ:  state_in = S_A_SQW;
         S_A_SQW: begin
            if (sq_done) begin
               slen_in  = sq_root;
               state_in = S_A_VEC;
            end
         end
         S_A_VEC:  state_in = S_A_VECW;
         S_A_VECW: begin
            if (crsp.done) begin
               wr_idx = IW'(count_ff);
               j_we   = 1'b1;
               hd_we  = 1'b1;
               len_we = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in.status     = ST_ADDED;
               rsp_in.bone_index = 4'(count_ff);
               rsp_in.out_x      = tx_ff;
               rsp_in.out_y      = ty_ff;
               rsp_in.out_angle  = crsp.angle;
               rsp_in.out_length = slen_ff;
               rsp_in.last       = 1'b1;
               state_in = S_OUT;
            end
         end
         S_B_VEC:  state_in = S_B_VECW;
         S_B_VECW: begin
            if (crsp.done) begin
               hd_we    = 1'b1;
               state_in = S_B_ROT;
            end
         end
         S_B_ROT:  state_in = S_B_ROTW;
         S_B_ROTW: begin
            if (crsp.done) begin
               wjx  = nx;
               wjy  = ny;
               j_we = 1'b1;
               if (idx_ff == '0) begin
                  tx_in    = root_x_ff;
                  ty_in    = root_y_ff;
                  state_in = S_F_ROT1;
               end else begin
                  tx_in    = nx;
                  ty_in    = ny;
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_B_VEC;
               end
            end
         end
         S_F_ROT1: state_in = S_F_RT1W;
         S_F_RT1W: begin
            if (crsp.done) begin
               tipx_in  = 21'(rjx) + 21'(crsp.ox);
               tipy_in  = 21'(rjy) + 21'(crsp.oy);
               state_in = S_F_VEC;
            end
         end
         S_F_VEC:  state_in = S_F_VECW;
         S_F_VECW: begin
            if (crsp.done) begin
               hd_we    = 1'b1;
               j_we     = 1'b1;
               state_in = S_F_ROT2;
            end
         end
         S_F_ROT2: state_in = S_F_RT2W;
         S_F_RT2W: begin
            if (crsp.done) begin
               rsp_in.status     = ST_SOLVED;
               rsp_in.bone_index = 4'(idx_ff);
               rsp_in.out_x      = tx_ff;
               rsp_in.out_y      = ty_ff;
               rsp_in.out_angle  = rhd;
               rsp_in.out_length = rlen;
               rsp_in.last       = (CW'(idx_ff) + 1'b1) == count_ff;
               tx_in    = nx;
               ty_in    = ny;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (rsp_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_F_ROT1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         has_root_ff <= 1'b0;
         root_x_ff   <= '0;
         root_y_ff   <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         has_root_ff <= has_root_in;
         root_x_ff   <= root_x_in;
         root_y_ff   <= root_y_in;
         count_ff    <= count_in;
      end
      idx_ff  <= idx_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      tipx_ff <= tipx_in;
      tipy_ff <= tipy_in;
      slen_ff <= slen_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (j_we) begin
         jx_ff[wr_idx] <= wjx;
         jy_ff[wr_idx] <= wjy;
      end
      if (hd_we) hd_ff[wr_idx] <= whd;
      if (len_we) len_ff[wr_idx] <= slen_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("accepting input while a result is pending");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BONES))
      else $error("bone count beyond capacity");

   a_solved_has_bones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ff.status == ST_SOLVED) |-> count_ff != '0)
      else $error("solved bone reported on an empty chain");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_VECW) && crsp.done |=> count_ff == $past(count_ff) + 1'b1)
      else $error("bone add did not advance the count");

endmodule

[tb/tb_planar_chain_ik_solver.sv]
// ----------------------------------------------------------------------------
// tb_planar_chain_ik_solver
// Self-checking bench for the planar chain IK solver. A queue of add and step
// transactions (directed corners, then random chains built toward the bone
// limit) feeds a clocked driver. An in-bench fixed-point chain model predicts
// every result. A clocked monitor compares each result field by field.
// Random idling on both channels runs in phases. One long receiver hold-off
// and one sender pause until drained are included.
// ----------------------------------------------------------------------------
module tb_planar_chain_ik_solver;
   timeunit 1ns;
   timeprecision 1ps;
   import cpik_pkg::*;

   localparam int BONES    = 16;
   localparam int ITERS    = 16;
   localparam int WD_LIMIT = 30000;
   localparam int HOLD_LEN = 400;
   localparam int PAUSE_AT = 150;
   localparam int HOLD_AT  = 300;

   localparam int unsigned ARC [16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   planar_chain_ik_solver dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // chain model state
   bit          chain_rooted;
   int          base_x, base_y;
   int          bone_count;
   int          jx [BONES];
   int          jy [BONES];
   logic [15:0] hd [BONES];
   logic [16:0] bl [BONES];

   req_type pending[$];
   rsp_type expected_bones[$];
   int      sent, results, errors, idle_cycles;
   bit      paused_once, held_once;
   int      hold_cnt;

   function automatic int sat16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : int'(v));
   endfunction

   function automatic logic [15:0] heading_of(longint dx, longint dy);
      longint x, y, xs, ys;
      bit [31:0] z;
      x = dx * 16384;
      y = dy * 16384;
      z = 0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ARC[i];
         end else begin
            x -= ys; y += xs; z -= ARC[i];
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   task automatic rotate_len(input logic [16:0] len, input logic [15:0] ang,
                             output longint ox, output longint oy);
      bit [31:0] z32, t;
      bit        flip;
      longint    x, y, z, xs, ys;
      z32 = {ang, 16'h0000};
      t = z32 + 32'h4000_0000;
      flip = 0;
      if (t >= 32'h8000_0000) begin
         z32 = z32 + 32'h8000_0000;
         flip = 1;
      end
      z = longint'(int'(z32));
      x = (longint'(len) * 652032874) >>> 14;
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ARC[i];
         end else begin
            x += ys; y -= xs; z += ARC[i];
         end
      end
      x = (x + 32768) >>> 16;
      y = (y + 32768) >>> 16;
      ox = flip ? -x : x;
      oy = flip ? -y : y;
   endtask

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic rsp_type mk(logic [2:0] st, int idx, int x, int y,
                                  logic [15:0] a, logic [16:0] l, logic lst);
      rsp_type r;
      r.status = st;
      r.bone_index = idx[3:0];
      r.out_x = x[15:0];
      r.out_y = y[15:0];
      r.out_angle = a;
      r.out_length = l;
      r.last = lst;
      return r;
   endfunction

   task automatic predict_chain(input req_type t);
      int      px, py, sx, sy, n, tx, ty;
      longint  ex, ey, dx, dy, tipx, tipy;
      longint unsigned len;
      px = t.point_x;
      py = t.point_y;
      n = bone_count;
      if (t.action == ACT_ADD) begin
         if (!chain_rooted) begin
            chain_rooted = 1;
            base_x = px;
            base_y = py;
            expected_bones.push_back(mk(ST_ROOT_SET, 0, px, py, 0, 0, 1));
         end else if (n >= BONES) begin
            expected_bones.push_back(mk(ST_FULL, 0, 0, 0, 0, 0, 1));
         end else begin
            if (n == 0) begin
               sx = base_x;
               sy = base_y;
            end else begin
               rotate_len(bl[n-1], hd[n-1], ex, ey);
               sx = sat16(jx[n-1] + ex);
               sy = sat16(jy[n-1] + ey);
            end
            dx = longint'(px) - sx;
            dy = longint'(py) - sy;
            len = root_floor(dx * dx + dy * dy);
            if (len > 131071) len = 131071;
            jx[n] = sx;
            jy[n] = sy;
            hd[n] = heading_of(dx, dy);
            bl[n] = len[16:0];
            bone_count = n + 1;
            expected_bones.push_back(mk(ST_ADDED, n, sx, sy, hd[n], bl[n], 1));
         end
      end else if (n == 0) begin
         expected_bones.push_back(mk(ST_EMPTY, 0, 0, 0, 0, 0, 1));
      end else begin
         tx = px;
         ty = py;
         for (int i = n - 1; i >= 0; i--) begin
            hd[i] = heading_of(longint'(tx) - jx[i], longint'(ty) - jy[i]);
            rotate_len(bl[i], hd[i] + HALF_TURN, ex, ey);
            jx[i] = sat16(tx + ex);
            jy[i] = sat16(ty + ey);
            tx = jx[i];
            ty = jy[i];
         end
         tx = base_x;
         ty = base_y;
         for (int i = 0; i < n; i++) begin
            rotate_len(bl[i], hd[i], ex, ey);
            tipx = jx[i] + ex;
            tipy = jy[i] + ey;
            hd[i] = heading_of(tipx - tx, tipy - ty);
            jx[i] = tx;
            jy[i] = ty;
            rotate_len(bl[i], hd[i], ex, ey);
            tx = sat16(tx + ex);
            ty = sat16(ty + ey);
            expected_bones.push_back(mk(ST_SOLVED, i, jx[i], jy[i], hd[i], bl[i],
                                        i + 1 == n));
         end
      end
   endtask

   function automatic int phase_of(int k);
      return k < 80 ? 0 : (k < 150 ? 1 : (k < 220 ? 2 : 3));
   endfunction

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic bit sender_idle(int k);
      case (phase_of(k))
         1: begin
            return roll(57);
         end
         3: begin
            return roll(9);
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic bit receiver_stall(int k);
      case (phase_of(k))
         2: begin
            return roll(57);
         end
         3: begin
            return roll(9);
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   task automatic queue_item(logic act, int x, int y);
      req_type t;
      t.action = act;
      t.point_x = x[15:0];
      t.point_y = y[15:0];
      pending.push_back(t);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_chain(req_data);
            sent <= sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending.size() == 0 || sender_idle(sent)
                || (!paused_once && sent >= PAUSE_AT && expected_bones.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               if (sent >= PAUSE_AT) paused_once <= 1;
               req_valid <= 1'b1;
               req_data <= pending.pop_front();
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results <= results + 1;
            if (expected_bones.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_bones.pop_front();
               if (want.status != rsp_data.status || want.bone_index != rsp_data.bone_index
                   || want.out_x != rsp_data.out_x || want.out_y != rsp_data.out_y
                   || want.out_angle != rsp_data.out_angle
                   || want.out_length != rsp_data.out_length || want.last != rsp_data.last) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  errors <= errors + 1;
               end
            end
         end
         if (!held_once && results >= HOLD_AT) begin
            held_once <= 1;
            hold_cnt <= HOLD_LEN;
            rsp_ready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !receiver_stall(sent);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("tb_planar_chain_ik_solver: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int bones, total;
      sent = 0;
      results = 0;
      errors = 0;
      idle_cycles = 0;
      hold_cnt = 0;
      chain_rooted = 0;
      base_x = 0;
      base_y = 0;
      bone_count = 0;
      queue_item(ACT_STEP, 100, -100);
      queue_item(ACT_ADD, -32768, -32768);
      queue_item(ACT_ADD, -32768, -32768);
      queue_item(ACT_ADD, 32767, 32767);
      queue_item(ACT_ADD, -32768, 32767);
      queue_item(ACT_ADD, 0, 0);
      queue_item(ACT_STEP, 0, 0);
      queue_item(ACT_STEP, 32767, -32768);
      queue_item(ACT_STEP, -32768, 32767);
      bones = 4;
      total = pending.size();
      while (total < 290) begin
         if (bones < BONES && roll(35)) begin
            queue_item(ACT_ADD, $urandom_range(400) - 200, $urandom_range(400) - 200);
            bones++;
         end else if (roll(6)) begin
            queue_item(ACT_ADD, int'($urandom), int'($urandom));
            if (bones < BONES) bones++;
         end else if (roll(50)) begin
            queue_item(ACT_STEP, int'($urandom), int'($urandom));
         end else begin
            queue_item(ACT_STEP, $urandom_range(2000) - 1000, $urandom_range(2000) - 1000);
         end
         total++;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid && expected_bones.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_bones.size() == 0) begin
         $display("tb_planar_chain_ik_solver: PASS");
      end else begin
         $display("tb_planar_chain_ik_solver: FAIL");
      end
      $finish;
   end

endmodule
